@@ design/cfd_pkg.sv @@
// Shared types, constants and the CRC byte function of the command frame decoder.
package cfd_pkg;

  localparam int unsigned FRAME_BYTES = 12;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned CFG_IDX_W   = 8;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      word_t;
  typedef logic [31:0]      tick_t;

  localparam pos_t POS_HDR0   = pos_t'(0);
  localparam pos_t POS_HDR1   = pos_t'(1);
  localparam pos_t POS_CODE   = pos_t'(2);
  localparam pos_t POS_ARG_HI = pos_t'(3);
  localparam pos_t POS_ARG_LO = pos_t'(4);
  localparam pos_t POS_CRC_HI = pos_t'(9);
  localparam pos_t POS_CRC_LO = pos_t'(10);
  localparam pos_t POS_LAST   = pos_t'(FRAME_BYTES - 1);
  localparam pos_t CRC_SPAN   = pos_t'(9);

  localparam byte_t HDR_FIRST  = 8'h42;
  localparam byte_t HDR_SECOND = 8'h4B;
  localparam byte_t TAIL_BYTE  = 8'h4B;
  localparam word_t CRC_INIT   = 16'hFFFF;
  localparam word_t CRC_POLY   = 16'h1021;
  localparam word_t STOP_PWM   = word_t'(1000 - 1);

  localparam byte_t READ_CODE_RST      = 8'd1;
  localparam byte_t WRITE_CODE_RST     = 8'd2;
  localparam byte_t STOP_CODE_RST      = 8'd4;
  localparam byte_t HEARTBEAT_CODE_RST = 8'd5;

  typedef enum logic [1:0] {
    STAT_GOOD      = 2'd0,
    STAT_FRAME_ERR = 2'd1,
    STAT_CRC_ERR   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ      = 8'd0,
    REG_WRITE     = 8'd1,
    REG_STOP      = 8'd2,
    REG_HEARTBEAT = 8'd3
  } reg_idx_e;

  // Summary of a finished frame, handed from the frame tracker to the command stage.
  typedef struct packed {
    logic  done;
    logic  hdr_ok;
    logic  crc_ok;
    byte_t code;
    word_t arg;
    tick_t now;
  } frame_t;

  // CRC-16-CCITT, MSB first, one byte per call.
  function automatic word_t crc_byte(input word_t crc, input byte_t b);
    word_t c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ design/cfd_if.sv @@
// Handshake interfaces for the byte input, the result output and the register write port.
interface cfd_byte_if import cfd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  tick_t now_ms;

  modport source (output valid, rx_byte, now_ms, input ready);
  modport sink   (input valid, rx_byte, now_ms, output ready);
  modport mon    (input valid, ready, rx_byte, now_ms);
endinterface

interface cfd_result_if import cfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  byte_t      command_code;
  word_t      poll_period;
  word_t      pwm_high_time;
  tick_t      heartbeat_time;

  modport source (output valid, frame_status, command_code, poll_period, pwm_high_time,
                  heartbeat_time, input ready);
  modport sink   (input valid, frame_status, command_code, poll_period, pwm_high_time,
                  heartbeat_time, output ready);
  modport mon    (input valid, ready, frame_status, command_code, poll_period,
                  pwm_high_time, heartbeat_time);
endinterface

interface cfd_cfg_if import cfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  byte_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

@@ design/command_frame_decoder.sv @@
// Top level of the command frame decoder: frame tracking and command update.
//
//   channel  | dir | payload                                     | word
//   rx_i     | in  | rx_byte, now_ms                             | one received byte
//   res_o    | out | frame_status, command_code, poll_period,    | one frame result
//            |     | pwm_high_time, heartbeat_time               |
//   cfg_i    | in  | index, data                                 | one code register write
//
// One byte word is taken every cycle unless a frame's last byte waits for the result
// slot; the twelfth byte of a frame passes the input register, then the result register.
// The CRC step for one byte is a single unrolled 8-bit update after the input register.
// A stalled result blocks only the last byte of the next frame; middle bytes keep flowing.
// Reset clears the frame position, CRC, held values and restores the default codes.
module command_frame_decoder import cfd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfd_byte_if.sink     rx_i,
  cfd_cfg_if.sink      cfg_i,
  cfd_result_if.source res_o
);

  frame_t frame;
  logic   res_free;

  cfd_frame_track u_frame_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .res_free_i (res_free),
    .frame_o    (frame)
  );

  cfd_cmd_update u_cmd_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .frame_i    (frame),
    .res_free_o (res_free),
    .res_o      (res_o)
  );

endmodule

@@ design/cfd_frame_track.sv @@
// Input word register, byte position, running CRC and captured frame fields.
module cfd_frame_track import cfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cfd_byte_if.sink         rx_i,
  input  logic             res_free_i,
  output frame_t           frame_o
);

  logic  s1_valid_q;
  byte_t s1_byte_q;
  tick_t s1_now_q;

  pos_t  pos_q, pos_d;
  word_t crc_q, crc_d;
  logic  hdr_q, hdr_d;
  byte_t code_q, code_d;
  word_t arg_q, arg_d;
  word_t chk_q, chk_d;

  logic is_last;
  logic fire;

  // A middle byte needs no result slot; only the last byte waits for one.
  assign is_last    = (pos_q == POS_LAST);
  assign fire       = s1_valid_q && (!is_last || res_free_i);
  assign rx_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
      s1_now_q  <= rx_i.now_ms;
    end
  end

  always_comb begin
    pos_d  = pos_q + pos_t'(1);
    crc_d  = (pos_q < CRC_SPAN) ? crc_byte(crc_q, s1_byte_q) : crc_q;
    hdr_d  = hdr_q;
    code_d = code_q;
    arg_d  = arg_q;
    chk_d  = chk_q;
    unique case (pos_q)
      POS_HDR0:   hdr_d = hdr_q && (s1_byte_q == HDR_FIRST);
      POS_HDR1:   hdr_d = hdr_q && (s1_byte_q == HDR_SECOND);
      POS_CODE:   code_d = s1_byte_q;
      POS_ARG_HI: arg_d = {s1_byte_q, arg_q[7:0]};
      POS_ARG_LO: arg_d = {arg_q[15:8], s1_byte_q};
      POS_CRC_HI: chk_d = {s1_byte_q, chk_q[7:0]};
      POS_CRC_LO: chk_d = {chk_q[15:8], s1_byte_q};
      default: ;
    endcase
    if (is_last) begin
      pos_d = '0;
      crc_d = CRC_INIT;
      hdr_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CRC_INIT;
      hdr_q <= 1'b1;
    end else if (fire) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      hdr_q <= hdr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      code_q <= code_d;
      arg_q  <= arg_d;
      chk_q  <= chk_d;
    end
  end

  assign frame_o.done   = fire && is_last;
  assign frame_o.hdr_ok = hdr_q && (s1_byte_q == TAIL_BYTE);
  assign frame_o.crc_ok = (chk_q == crc_q);
  assign frame_o.code   = code_q;
  assign frame_o.arg    = arg_q;
  assign frame_o.now    = s1_now_q;

endmodule

@@ design/cfd_cmd_update.sv @@
// Function code registers, held command values and the result register.
module cfd_cmd_update import cfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfd_cfg_if.sink     cfg_i,
  input  frame_t      frame_i,
  output logic        res_free_o,
  cfd_result_if.source res_o
);

  byte_t read_code_q, write_code_q, stop_code_q, hb_code_q;
  byte_t held_code_q, held_code_d;
  word_t held_period_q, held_period_d;
  word_t held_pwm_q, held_pwm_d;
  tick_t held_time_q, held_time_d;
  status_e status_d;

  logic    res_valid_q;
  status_e res_status_q;
  byte_t   res_code_q;
  word_t   res_period_q;
  word_t   res_pwm_q;
  tick_t   res_time_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_code_q  <= READ_CODE_RST;
      write_code_q <= WRITE_CODE_RST;
      stop_code_q  <= STOP_CODE_RST;
      hb_code_q    <= HEARTBEAT_CODE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_READ:      read_code_q  <= cfg_i.data;
        REG_WRITE:     write_code_q <= cfg_i.data;
        REG_STOP:      stop_code_q  <= cfg_i.data;
        REG_HEARTBEAT: hb_code_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A header or tail fault wins over a CRC fault; only a clean frame touches the held values.
  always_comb begin
    held_code_d   = held_code_q;
    held_period_d = held_period_q;
    held_pwm_d    = held_pwm_q;
    held_time_d   = held_time_q;
    priority if (!frame_i.hdr_ok) begin
      status_d = STAT_FRAME_ERR;
    end else if (!frame_i.crc_ok) begin
      status_d = STAT_CRC_ERR;
    end else begin
      status_d    = STAT_GOOD;
      held_code_d = frame_i.code;
      priority if (frame_i.code == read_code_q) begin
        held_period_d = frame_i.arg;
      end else if (frame_i.code == write_code_q) begin
        held_pwm_d = frame_i.arg;
      end else if (frame_i.code == stop_code_q) begin
        held_pwm_d    = STOP_PWM;
        held_period_d = '0;
      end else if (frame_i.code == hb_code_q) begin
        held_time_d = frame_i.now;
      end else begin
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_code_q   <= '0;
      held_period_q <= '0;
      held_pwm_q    <= '0;
      held_time_q   <= '0;
    end else if (frame_i.done) begin
      held_code_q   <= held_code_d;
      held_period_q <= held_period_d;
      held_pwm_q    <= held_pwm_d;
      held_time_q   <= held_time_d;
    end
  end

  assign res_free_o = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free_o) begin
      res_valid_q <= frame_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.done) begin
      res_status_q <= status_d;
      res_code_q   <= held_code_d;
      res_period_q <= held_period_d;
      res_pwm_q    <= held_pwm_d;
      res_time_q   <= held_time_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.frame_status   = res_status_q;
  assign res_o.command_code   = res_code_q;
  assign res_o.poll_period    = res_period_q;
  assign res_o.pwm_high_time  = res_pwm_q;
  assign res_o.heartbeat_time = res_time_q;

endmodule

@@ design/cfd_checker.sv @@
// Port-level assertions for the command frame decoder and their bind.
module cfd_checker import cfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_status_i,
  input byte_t      res_code_i,
  input tick_t      res_time_i
);

  pos_t       cnt_q;
  logic [2:0] pend_q;
  logic       in_acc;
  logic       out_acc;
  logic       frame_end;

  assign in_acc    = rx_valid_i && rx_ready_i;
  assign out_acc   = res_valid_i && res_ready_i;
  assign frame_end = in_acc && (cnt_q == POS_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      if (in_acc) begin
        cnt_q <= (cnt_q == POS_LAST) ? '0 : cnt_q + pos_t'(1);
      end
      pend_q <= pend_q + 3'(frame_end) - 3'(out_acc);
    end
  end

  // Every offered result belongs to a frame whose last byte word has been taken.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pend_q != 3'd0)
    else $error("result offered without a completed frame");

  // At most the input register and the result register hold finished frames.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("too many finished frames without a result");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn before it was taken");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_status_i) &&
      $stable(res_code_i) && $stable(res_time_i))
    else $error("stalled result changed");

endmodule

bind command_frame_decoder cfd_checker u_cfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_valid_i   (rx_i.valid),
  .rx_ready_i   (rx_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.frame_status),
  .res_code_i   (res_o.command_code),
  .res_time_i   (res_o.heartbeat_time)
);

@@ tb/sv/command_frame_decoder_test.sv @@
// Self-checking bench for the command frame decoder: byte stream in, frame reports out.
module command_frame_decoder_test;
  import cfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int SETTLE_WAIT  = 4;
  localparam int PRINT_CAP    = 50;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_FRAMES = 10;

  // Fault flags for building broken frames.
  localparam int FLT_HDR0 = 1;
  localparam int FLT_HDR1 = 2;
  localparam int FLT_TAIL = 4;
  localparam int FLT_CRC  = 8;
  localparam int FLT_ALL  = 15;

  typedef struct {
    byte_t data;
    tick_t now;
  } rx_word_t;

  typedef struct {
    status_e status;
    byte_t   code;
    word_t   period;
    word_t   pwm;
    tick_t   beat;
  } frame_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cfd_byte_if   rx_if ();
  cfd_cfg_if    cfg_if ();
  cfd_result_if res_if ();

  command_frame_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #2 clk_i = ~clk_i;

  rx_word_t      byte_stream[$];
  frame_report_t frame_reports_due[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  bit  rx_taken       = 1'b0;

  // Predictor state: code registers, frame tracker and held command.
  byte_t code_read, code_write, code_stop, code_beat;
  pos_t  frame_pos;
  word_t crc_run;
  logic  frame_ok;
  byte_t frame_code;
  word_t frame_arg;
  word_t frame_crc;
  byte_t held_code;
  word_t held_period;
  word_t held_pwm;
  tick_t held_beat;

  function automatic word_t crc_step(word_t c, byte_t b);
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ b[i]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void restart_frame();
    frame_pos  = '0;
    crc_run    = CRC_INIT;
    frame_ok   = 1'b1;
    frame_code = '0;
    frame_arg  = '0;
    frame_crc  = '0;
  endfunction

  function automatic void reset_decoder();
    code_read   = READ_CODE_RST;
    code_write  = WRITE_CODE_RST;
    code_stop   = STOP_CODE_RST;
    code_beat   = HEARTBEAT_CODE_RST;
    held_code   = '0;
    held_period = '0;
    held_pwm    = '0;
    held_beat   = '0;
    restart_frame();
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, byte_t v);
    case (idx)
      REG_READ:      code_read  = v;
      REG_WRITE:     code_write = v;
      REG_STOP:      code_stop  = v;
      REG_HEARTBEAT: code_beat  = v;
      default: ;
    endcase
  endfunction

  // Advances the frame tracker by one byte word; the last byte of a frame yields a report.
  function automatic void decode_byte(byte_t b, tick_t now);
    frame_report_t rep;
    if (frame_pos < CRC_SPAN) crc_run = crc_step(crc_run, b);
    case (frame_pos)
      POS_HDR0:   if (b != HDR_FIRST) frame_ok = 1'b0;
      POS_HDR1:   if (b != HDR_SECOND) frame_ok = 1'b0;
      POS_CODE:   frame_code = b;
      POS_ARG_HI: frame_arg[15:8] = b;
      POS_ARG_LO: frame_arg[7:0] = b;
      POS_CRC_HI: frame_crc[15:8] = b;
      POS_CRC_LO: frame_crc[7:0] = b;
      default: ;
    endcase
    if (frame_pos != POS_LAST) begin
      frame_pos = frame_pos + pos_t'(1);
      return;
    end
    if (b != TAIL_BYTE) frame_ok = 1'b0;
    if (!frame_ok) begin
      rep.status = STAT_FRAME_ERR;
    end else if (frame_crc != crc_run) begin
      rep.status = STAT_CRC_ERR;
    end else begin
      rep.status = STAT_GOOD;
      held_code  = frame_code;
      // The first matching register wins when several hold the same code.
      if (frame_code == code_read) begin
        held_period = frame_arg;
      end else if (frame_code == code_write) begin
        held_pwm = frame_arg;
      end else if (frame_code == code_stop) begin
        held_pwm    = STOP_PWM;
        held_period = '0;
      end else if (frame_code == code_beat) begin
        held_beat = now;
      end
    end
    rep.code   = held_code;
    rep.period = held_period;
    rep.pwm    = held_pwm;
    rep.beat   = held_beat;
    frame_reports_due.push_back(rep);
    restart_frame();
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Queues one frame; the now value rides on the last byte, the others get random ticks.
  function automatic void queue_frame(byte_t code, word_t arg, tick_t now, int faults);
    byte_t    f[FRAME_BYTES];
    word_t    c;
    rx_word_t w;
    c = CRC_INIT;
    f[0] = HDR_FIRST;
    f[1] = HDR_SECOND;
    f[2] = code;
    f[3] = arg[15:8];
    f[4] = arg[7:0];
    for (int i = 5; i < 9; i++) f[i] = byte_t'($urandom);
    for (int i = 0; i < 9; i++) c = crc_step(c, f[i]);
    f[9]  = c[15:8];
    f[10] = c[7:0];
    f[11] = TAIL_BYTE;
    if (faults & FLT_HDR0) f[0] ^= byte_t'($urandom_range(255, 1));
    if (faults & FLT_HDR1) f[1] ^= byte_t'($urandom_range(255, 1));
    if (faults & FLT_TAIL) f[11] ^= byte_t'($urandom_range(255, 1));
    if (faults & FLT_CRC) f[9 + $urandom_range(1)] ^= byte_t'($urandom_range(255, 1));
    for (int i = 0; i < FRAME_BYTES; i++) begin
      w.data = f[i];
      w.now  = (i == FRAME_BYTES - 1) ? now : tick_t'($urandom);
      byte_stream.push_back(w);
    end
  endfunction

  function automatic void queue_noise();
    rx_word_t w;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      w.data = byte_t'($urandom);
      w.now  = tick_t'($urandom);
      byte_stream.push_back(w);
    end
  endfunction

  function automatic void queue_random_frame();
    int    pick = $urandom_range(99);
    int    sel  = $urandom_range(9);
    byte_t code;
    word_t arg;
    case ($urandom_range(5))
      0:       code = code_read;
      1:       code = code_write;
      2:       code = code_stop;
      3:       code = code_beat;
      4:       code = code_beat;
      default: code = byte_t'($urandom);
    endcase
    arg = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : word_t'($urandom);
    if (pick < 70) begin
      queue_frame(code, arg, tick_t'($urandom), 0);
    end else if (pick < 93) begin
      queue_frame(code, arg, tick_t'($urandom), $urandom_range(FLT_ALL, 1));
    end else begin
      queue_noise();
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, byte_t v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg_write(idx, v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_codes(byte_t r, byte_t w, byte_t s, byte_t h);
    write_reg(REG_READ, r);
    write_reg(REG_WRITE, w);
    write_reg(REG_STOP, s);
    write_reg(REG_HEARTBEAT, h);
  endtask

  // Waits until every byte word is taken and every report has come back.
  task automatic drain();
    while (byte_stream.size() != 0 || frame_reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Byte driver: holds a word until it is taken, then maybe idles before the next.
  always @(negedge clk_i) begin
    if (rst_ni && (!rx_if.valid || rx_taken)) begin
      rx_taken = 1'b0;
      if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= byte_stream[0].data;
        rx_if.now_ms  <= byte_stream[0].now;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    frame_report_t want;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        decode_byte(rx_if.rx_byte, rx_if.now_ms);
        void'(byte_stream.pop_front());
        rx_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        if (frame_reports_due.size() == 0) begin
          report_mismatch("frame report with nothing expected");
        end else begin
          want = frame_reports_due.pop_front();
          check_field("frame_status", res_if.frame_status, want.status);
          check_field("command_code", res_if.command_code, want.code);
          check_field("poll_period", res_if.poll_period, want.period);
          check_field("pwm_high_time", res_if.pwm_high_time, want.pwm);
          check_field("heartbeat_time", res_if.heartbeat_time, want.beat);
        end
      end
    end
  end

  initial begin
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    rx_if.now_ms   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    res_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    reset_decoder();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames with the default codes: every command, extremes and each fault.
    queue_frame(READ_CODE_RST, 16'hFFFF, 32'h1234_5678, 0);
    queue_frame(WRITE_CODE_RST, 16'hFFFF, 32'h0, 0);
    queue_frame(READ_CODE_RST, 16'h0000, 32'h0, 0);
    queue_frame(HEARTBEAT_CODE_RST, 16'h5A5A, 32'hFFFF_FFFF, 0);
    queue_frame(STOP_CODE_RST, 16'h1234, 32'hFFFF_FFFF, 0);
    queue_frame(WRITE_CODE_RST, 16'h0000, 32'h0, 0);
    queue_frame(HEARTBEAT_CODE_RST, 16'hA5A5, 32'h0, 0);
    queue_frame(8'h00, 16'hBEEF, 32'h0, 0);
    queue_frame(8'hFF, 16'h8001, 32'hFFFF_FFFF, 0);
    queue_frame(WRITE_CODE_RST, 16'h7777, 32'h0, FLT_HDR0);
    queue_frame(READ_CODE_RST, 16'h3333, 32'h0, FLT_HDR1);
    queue_frame(STOP_CODE_RST, 16'h0, 32'h0, FLT_TAIL);
    queue_frame(HEARTBEAT_CODE_RST, 16'h0, 32'hCAFE_F00D, FLT_CRC);
    queue_frame(READ_CODE_RST, 16'h4444, 32'h0, FLT_ALL);
    queue_noise();
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          load_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
          // Writes to indexes past the last register must change nothing.
          write_reg(CFG_IDX_W'(4), 8'h00);
          write_reg(CFG_IDX_W'(255), 8'hFF);
          write_reg(CFG_IDX_W'($urandom_range(254, 5)), byte_t'($urandom));
        end
        1: load_codes(8'h33, 8'h33, 8'h33, 8'h33);
        2: load_codes(8'h10, 8'h20, 8'h20, 8'h20);
        3: load_codes(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                      byte_t'($urandom));
        default: load_codes(READ_CODE_RST, WRITE_CODE_RST, STOP_CODE_RST,
                            HEARTBEAT_CODE_RST);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_FRAMES; n++) queue_random_frame();
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (frame_reports_due.size() != 0) report_mismatch("frame reports never arrived");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ command_frame_decoder.f @@
design/cfd_pkg.sv
design/cfd_if.sv
design/cfd_frame_track.sv
design/cfd_cmd_update.sv
design/command_frame_decoder.sv
design/cfd_checker.sv
tb/sv/command_frame_decoder_test.sv
